/* rtl/tts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_pkg
// Types and constants shared by the timer to sample timestamp block.
// ----------------------------------------------------------------------------
package tts_pkg;

    localparam int TICK_W   = 32;
    localparam int SAMPLE_W = 64;
    localparam int RATIO_W  = 32;
    localparam int FUNC_W   = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [FUNC_W-1:0] FUNC_PUBLISH = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CONVERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_GUARDED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_IDX = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD_IDX = 4'd1;

    typedef struct packed {
        logic [RATIO_W-1:0] samples_per_tick_q32;
        logic [31:0]        guard_samples;
    } cfg_t;

    typedef struct packed {
        logic                  ok;
        logic                  neg;
        logic                  guarded;
        logic [63:0]           prod;
        logic [SAMPLE_W-1:0]   anchor_sample;
    } prod_t;

    typedef struct packed {
        logic                ok;
        logic                guarded;
        logic [SAMPLE_W-1:0] t;
    } sum_t;

endpackage

/* rtl/tts_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_req_if
// Input item channel: function code, timer tick and audio sample.
// ----------------------------------------------------------------------------
interface tts_req_if;
    import tts_pkg::*;

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [TICK_W-1:0]   timer_tick;
    logic [SAMPLE_W-1:0] sample_idx;

    modport source (output valid, output func, output timer_tick, output sample_idx,
                    input ready);
    modport sink (input valid, input func, input timer_tick, input sample_idx,
                  output ready);
endinterface

/* rtl/tts_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_rsp_if
// Result channel: status flag and converted sample time.
// ----------------------------------------------------------------------------
interface tts_rsp_if;
    import tts_pkg::*;

    logic                valid;
    logic                ready;
    logic                ok;
    logic [SAMPLE_W-1:0] sample_stamp;

    modport source (output valid, output ok, output sample_stamp, input ready);
    modport sink (input valid, input ok, input sample_stamp, output ready);
endinterface

/* rtl/tts_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tts_cfg_if;
    import tts_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/tts_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_cfg_regs
// Holds the ratio and guard registers written through the configuration port.
// ----------------------------------------------------------------------------
module tts_cfg_regs
(
    input  logic         clk,
    input  logic         rst_n,
    tts_cfg_if.sink      cfg,
    output tts_pkg::cfg_t regs
);
    import tts_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_RATIO_IDX: regs_next.samples_per_tick_q32 = cfg.data;
                CFG_GUARD_IDX: regs_next.guard_samples        = cfg.data;
                default:       regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= '0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end
endmodule

/* rtl/tts_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_front
// Input register, anchor storage, tick difference and ratio multiplication.
// ----------------------------------------------------------------------------
module tts_front
(
    input  logic          clk,
    input  logic          rst_n,
    tts_req_if.sink       req,
    input  tts_pkg::cfg_t regs,
    input  logic          down_ready,
    output logic          prod_valid,
    output tts_pkg::prod_t prod
);
    import tts_pkg::*;

    logic                s1_valid_reg;
    logic [FUNC_W-1:0]   s1_func_reg;
    logic [TICK_W-1:0]   s1_tick_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;

    logic [TICK_W-1:0]   anchor_tick_reg;
    logic [SAMPLE_W-1:0] anchor_sample_reg;
    logic                anchor_valid_reg;

    logic                prod_valid_reg;
    prod_t               prod_reg;
    prod_t               prod_next;

    logic                s2_ready;
    logic                s1_ready;
    logic                advance;
    logic                is_publish;
    logic                is_convert;
    logic [TICK_W-1:0]   diff;
    logic [TICK_W-1:0]   mag;

    assign s2_ready   = !prod_valid_reg || down_ready;
    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign advance    = s1_valid_reg && s2_ready;
    assign req.ready  = s1_ready;
    assign is_publish = (s1_func_reg == FUNC_PUBLISH);
    assign is_convert = (s1_func_reg == FUNC_CONVERT) || (s1_func_reg == FUNC_GUARDED);

    assign prod_valid = prod_valid_reg;
    assign prod       = prod_reg;

    always_comb
    begin
        diff = s1_tick_reg - anchor_tick_reg;
        mag  = diff[TICK_W-1] ? (~diff + 32'd1) : diff;
        prod_next.ok            = anchor_valid_reg && (regs.samples_per_tick_q32 != '0);
        prod_next.neg           = diff[TICK_W-1];
        prod_next.guarded       = (s1_func_reg == FUNC_GUARDED);
        prod_next.prod          = 64'(mag) * 64'(regs.samples_per_tick_q32);
        prod_next.anchor_sample = anchor_sample_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            prod_valid_reg    <= 1'b0;
            anchor_valid_reg  <= 1'b0;
            anchor_tick_reg   <= '0;
            anchor_sample_reg <= '0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s2_ready)
            begin
                prod_valid_reg <= advance && is_convert;
            end
            if (advance && is_publish)
            begin
                anchor_tick_reg   <= s1_tick_reg;
                anchor_sample_reg <= s1_sample_reg;
                anchor_valid_reg  <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && req.valid)
        begin
            s1_func_reg   <= req.func;
            s1_tick_reg   <= req.timer_tick;
            s1_sample_reg <= req.sample_idx;
        end
        if (advance)
        begin
            prod_reg <= prod_next;
        end
    end
endmodule

/* rtl/tts_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_back
// Rounding and anchor addition, then guard offset with saturation and the
// result register.
// ----------------------------------------------------------------------------
module tts_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           prod_valid,
    input  tts_pkg::prod_t prod,
    input  tts_pkg::cfg_t  regs,
    output logic           up_ready,
    tts_rsp_if.source      rsp
);
    import tts_pkg::*;

    logic                sum_valid_reg;
    sum_t                sum_reg;
    sum_t                sum_next;
    logic                out_valid_reg;
    logic                out_ok_reg;
    logic [SAMPLE_W-1:0] out_time_reg;
    logic [SAMPLE_W-1:0] out_time_next;

    logic                out_ready;
    logic                s3_ready;
    logic [31:0]         rmag;
    logic [SAMPLE_W:0]   guard_sum;

    assign out_ready = !out_valid_reg || rsp.ready;
    assign s3_ready  = !sum_valid_reg || out_ready;
    assign up_ready  = s3_ready;

    assign rsp.valid        = out_valid_reg;
    assign rsp.ok           = out_ok_reg;
    assign rsp.sample_stamp = out_time_reg;

    always_comb
    begin
        rmag = prod.prod[63:32] + {31'd0, prod.prod[31]};
        sum_next.ok      = prod.ok;
        sum_next.guarded = prod.guarded;
        if (!prod.ok)
        begin
            sum_next.t = '0;
        end
        else if (prod.neg)
        begin
            sum_next.t = prod.anchor_sample - {32'd0, rmag};
        end
        else
        begin
            sum_next.t = prod.anchor_sample + {32'd0, rmag};
        end
    end

    always_comb
    begin
        guard_sum = {1'b0, sum_reg.t} + {33'd0, regs.guard_samples};
        if (sum_reg.ok && sum_reg.guarded)
        begin
            out_time_next = guard_sum[SAMPLE_W] ? '1 : guard_sum[SAMPLE_W-1:0];
        end
        else
        begin
            out_time_next = sum_reg.t;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_ready)
            begin
                sum_valid_reg <= prod_valid;
            end
            if (out_ready)
            begin
                out_valid_reg <= sum_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && prod_valid)
        begin
            sum_reg <= sum_next;
        end
        if (out_ready && sum_valid_reg)
        begin
            out_ok_reg   <= sum_reg.ok;
            out_time_reg <= out_time_next;
        end
    end
endmodule

/* rtl/timer_to_sample_timestamp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_to_sample_timestamp
// Throughput: one transaction per cycle while the sink keeps rsp.ready high,
// through a four-register pipeline (input, product, sum, result) that a convert
// result passes in order; publish transactions give no result.
// Reset clears the anchor valid flag, the anchor, both configuration
// registers and all pipeline valid flags.
// ----------------------------------------------------------------------------
module timer_to_sample_timestamp
(
    input  logic     clk,
    input  logic     rst_n,
    tts_req_if.sink  req,
    tts_rsp_if.source rsp,
    tts_cfg_if.sink  cfg
);
    import tts_pkg::*;

    cfg_t  regs;
    prod_t prod;
    logic  prod_valid;
    logic  back_ready;

    tts_cfg_regs u_cfg_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    tts_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .regs       (regs),
        .down_ready (back_ready),
        .prod_valid (prod_valid),
        .prod       (prod)
    );

    tts_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .prod_valid (prod_valid),
        .prod       (prod),
        .regs       (regs),
        .up_ready   (back_ready),
        .rsp        (rsp)
    );
endmodule

/* dv/timer_to_sample_timestamp_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_to_sample_timestamp_tb
// Self-checking testbench for the timer to sample timestamp converter. A table
// of directed transactions covers anchor updates, missing anchor, zero ratio,
// rounding, wrap, guard saturation and ignored selectors; random phases under
// varied ratio and guard settings follow. Every convert result is checked in
// order against table or predictor values; input is bursty, the sink stalls.
// ----------------------------------------------------------------------------
module timer_to_sample_timestamp_tb;
    import tts_pkg::*;

    localparam logic [FUNC_W-1:0]    FUNC_IGNORED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 4'd7;
    localparam int NUM_ROWS        = 31;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 5000;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;
    typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_PERIODIC, RDY_SPARSE} rdy_mode_e;

    typedef struct packed {
        row_kind_e            kind;
        logic [FUNC_W-1:0]    func;
        logic [CFG_IDX_W-1:0] idx;
        logic [TICK_W-1:0]    tick;
        logic [63:0]          val;
        logic                 typed;
        logic                 exp_ok;
        logic [SAMPLE_W-1:0]  exp_time;
    } dir_row_t;

    typedef struct packed {
        logic                ok;
        logic [SAMPLE_W-1:0] sample_stamp;
    } timestamp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic rsp_ready = 1'b1;

    tts_req_if req_if ();
    tts_rsp_if rsp_if ();
    tts_cfg_if cfg_if ();

    assign rsp_if.ready = rsp_ready;

    timer_to_sample_timestamp dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic                typed_valid;
    logic                typed_ok;
    logic [SAMPLE_W-1:0] typed_time;

    logic [TICK_W-1:0]   shadow_anchor_tick   = '0;
    logic [SAMPLE_W-1:0] shadow_anchor_sample = '0;
    logic                shadow_anchor_valid  = 1'b0;
    logic [RATIO_W-1:0]  shadow_ratio         = '0;
    logic [31:0]         shadow_guard         = '0;

    timestamp_t pending_timestamps[$];

    dir_row_t directed_rows [NUM_ROWS];
    logic [TICK_W-1:0] last_anchor_tick = '0;
    int burst_left = 0;
    int mismatches = 0;
    int n_accepted = 0;
    int n_publish = 0;
    int n_ignored = 0;
    int n_results = 0;
    int n_not_ok = 0;
    int n_saturated = 0;
    int n_cfg_writes = 0;
    int quiet_cycles = 0;

    function automatic timestamp_t convert_capture(logic [FUNC_W-1:0] func,
                                                   logic [TICK_W-1:0] tick);
        logic [31:0]         diff;
        logic                neg;
        logic [63:0]         mag_ticks;
        logic [63:0]         prod;
        logic [63:0]         mag;
        logic [SAMPLE_W-1:0] t;
        if (!shadow_anchor_valid || shadow_ratio == '0)
            return '{1'b0, 64'd0};
        diff = tick - shadow_anchor_tick;
        neg = diff[31];
        mag_ticks = neg ? {32'd0, 32'd0 - diff} : {32'd0, diff};
        prod = mag_ticks * {32'd0, shadow_ratio};
        mag = (prod + 64'h0000_0000_8000_0000) >> 32;
        t = neg ? shadow_anchor_sample - mag : shadow_anchor_sample + mag;
        if (func == FUNC_GUARDED)
        begin
            if (t > 64'hFFFF_FFFF_FFFF_FFFF - {32'd0, shadow_guard})
                t = 64'hFFFF_FFFF_FFFF_FFFF;
            else
                t = t + {32'd0, shadow_guard};
        end
        return '{1'b1, t};
    endfunction

    always @(posedge clk)
    begin
        timestamp_t want;
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                n_results++;
                if (pending_timestamps.size() == 0)
                begin
                    $display("%0t: unexpected result ok=%0b sample_stamp=%h", $time,
                             rsp_if.ok, rsp_if.sample_stamp);
                    mismatches++;
                end
                else
                begin
                    want = pending_timestamps.pop_front();
                    if (rsp_if.ok !== want.ok)
                    begin
                        $display("%0t: ok mismatch, expected %0b actual %0b", $time,
                                 want.ok, rsp_if.ok);
                        mismatches++;
                    end
                    if (rsp_if.sample_stamp !== want.sample_stamp)
                    begin
                        $display("%0t: sample_stamp mismatch, expected %h actual %h", $time,
                                 want.sample_stamp, rsp_if.sample_stamp);
                        mismatches++;
                    end
                end
            end
            if (cfg_if.valid && cfg_if.ready)
            begin
                n_cfg_writes++;
                case (cfg_if.index)
                    CFG_RATIO_IDX: shadow_ratio = cfg_if.data;
                    CFG_GUARD_IDX: shadow_guard = cfg_if.data;
                    default: ;
                endcase
            end
            if (req_if.valid && req_if.ready)
            begin
                n_accepted++;
                case (req_if.func)
                    FUNC_PUBLISH:
                    begin
                        n_publish++;
                        shadow_anchor_tick = req_if.timer_tick;
                        shadow_anchor_sample = req_if.sample_idx;
                        shadow_anchor_valid = 1'b1;
                    end
                    FUNC_CONVERT, FUNC_GUARDED:
                    begin
                        if (typed_valid)
                            want = '{typed_ok, typed_time};
                        else
                            want = convert_capture(req_if.func, req_if.timer_tick);
                        if (!want.ok)
                            n_not_ok++;
                        else if (req_if.func == FUNC_GUARDED && want.sample_stamp == '1)
                            n_saturated++;
                        pending_timestamps.push_back(want);
                    end
                    default: n_ignored++;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    rdy_mode_e rdy_mode = RDY_ALWAYS;
    int rdy_count = 0;

    always @(negedge clk)
    begin
        rdy_count++;
        if (rdy_count % 128 == 0)
            rdy_mode = rdy_mode_e'($urandom_range(3));
        case (rdy_mode)
            RDY_ALWAYS:   rsp_ready <= 1'b1;
            RDY_COIN:     rsp_ready <= 1'($urandom_range(1));
            RDY_PERIODIC: rsp_ready <= (rdy_count % 7) >= 3;
            default:      rsp_ready <= $urandom_range(9) != 0;
        endcase
    end

    // All tasks start and end at a falling edge.
    task automatic drive_item(logic [FUNC_W-1:0] func, logic [TICK_W-1:0] tick,
                              logic [SAMPLE_W-1:0] sample, logic typed,
                              logic t_ok, logic [SAMPLE_W-1:0] t_time);
        req_if.valid <= 1'b1;
        req_if.func <= func;
        req_if.timer_tick <= tick;
        req_if.sample_idx <= sample;
        typed_valid <= typed;
        typed_ok <= t_ok;
        typed_time <= t_time;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        @(negedge clk);
        if (func == FUNC_PUBLISH)
            last_anchor_tick = tick;
    endtask

    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(6, 1);
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(120, 50)
                                                  : $urandom_range(24, 1);
        end
    endtask

    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (pending_timestamps.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= data;
        do
            @(posedge clk);
        while (cfg_if.ready !== 1'b1);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        int                  counted;
        int                  pick;
        logic [RATIO_W-1:0]  ratio;
        logic [31:0]         guard;
        logic [31:0]         delta;
        logic [TICK_W-1:0]   tick;
        logic [SAMPLE_W-1:0] sample;
        logic [FUNC_W-1:0]   func;

        req_if.valid = 1'b0;
        req_if.func = FUNC_PUBLISH;
        req_if.timer_tick = '0;
        req_if.sample_idx = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_RATIO_IDX;
        cfg_if.data = '0;
        typed_valid = 1'b0;
        typed_ok = 1'b0;
        typed_time = '0;

        directed_rows = '{
            '{ROW_ITEM, FUNC_CONVERT, '0, 32'd5, 64'd0, 1'b1, 1'b0, 64'd0},
            '{ROW_ITEM, FUNC_GUARDED, '0, 32'hFFFF_FFFF, '1, 1'b1, 1'b0, 64'd0},
            '{ROW_ITEM, FUNC_IGNORED, '0, 32'hA5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, 1'b0, '0},
            '{ROW_ITEM, FUNC_PUBLISH, '0, 32'd100, 64'd1000, 1'b0, 1'b0, '0},
            '{ROW_ITEM, FUNC_CONVERT, '0, 32'd100, 64'd0, 1'b1, 1'b0, 64'd0},
            '{ROW_CFG, FUNC_PUBLISH, CFG_RATIO_IDX, '0, 64'h8000_0000, 1'b0, 1'b0, '0},
            '{ROW_CFG, FUNC_PUBLISH, CFG_GUARD_IDX, '0, 64'hFFFF_FFFF, 1'b0, 1'b0, '0},
            '{ROW_CFG, FUNC_PUBLISH, CFG_SPARE_IDX, '0, 64'h1234_5678, 1'b0, 1'b0, '0},
            '{ROW_ITEM, FUNC_CONVERT, '0, 32'd100, 64'd0, 1'b1, 1'b1, 64'd1000},
            '{ROW_ITEM, FUNC_CONVERT, '0, 32'd101, 64'd0, 1'b1, 1'b1, 64'd1001},
            '{ROW_ITEM, FUNC_CONVERT, '0, 32'd99, 64'd0, 1'b1, 1'b1, 64'd999},
            '{ROW_ITEM, FUNC_CONVERT, '0, 32'd103, 64'd0, 1'b1, 1'b1, 64'd1002},
            '{ROW_ITEM, FUNC_GUARDED, '0, 32'd100, 64'd0, 1'b1, 1'b1, 64'h1_0000_03E7},
            '{ROW_ITEM, FUNC_PUBLISH, '0, 32'd0, '1, 1'b0, 1'b0, '0},
            '{ROW_ITEM, FUNC_CONVERT, '0, 32'd2, 64'd0, 1'b1, 1'b1, 64'd0},
            '{ROW_ITEM, FUNC_GUARDED, '0, 32'd0, 64'd0, 1'b1, 1'b1, '1},
            '{ROW_ITEM, FUNC_CONVERT, '0, 32'h7FFF_FFFF, 64'd0, 1'b0, 1'b0, '0},
            '{ROW_ITEM, FUNC_PUBLISH, '0, 32'hFFFF_FFFF, 64'd0, 1'b0, 1'b0, '0},
            '{ROW_ITEM, FUNC_CONVERT, '0, 32'h7FFF_FFFF, 64'd0, 1'b0, 1'b0, '0},
            '{ROW_ITEM, FUNC_GUARDED, '0, 32'd0, 64'd0, 1'b0, 1'b0, '0},
            '{ROW_CFG, FUNC_PUBLISH, CFG_RATIO_IDX, '0, 64'hFFFF_FFFF, 1'b0, 1'b0, '0},
            '{ROW_CFG, FUNC_PUBLISH, CFG_GUARD_IDX, '0, 64'd0, 1'b0, 1'b0, '0},
            '{ROW_ITEM, FUNC_PUBLISH, '0, 32'h8000_0000, 64'h5555_5555_5555_5555, 1'b0, 1'b0, '0},
            '{ROW_ITEM, FUNC_CONVERT, '0, 32'd0, 64'd0, 1'b0, 1'b0, '0},
            '{ROW_ITEM, FUNC_CONVERT, '0, 32'h7FFF_FFFF, 64'd0, 1'b0, 1'b0, '0},
            '{ROW_ITEM, FUNC_GUARDED, '0, 32'hFFFF_FFFF, 64'd0, 1'b0, 1'b0, '0},
            '{ROW_ITEM, FUNC_PUBLISH, '0, 32'd0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, '0},
            '{ROW_ITEM, FUNC_CONVERT, '0, 32'd0, 64'd0, 1'b1, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA},
            '{ROW_CFG, FUNC_PUBLISH, CFG_RATIO_IDX, '0, 64'd1, 1'b0, 1'b0, '0},
            '{ROW_ITEM, FUNC_CONVERT, '0, 32'h7FFF_FFFF, 64'd0, 1'b1, 1'b1,
              64'hAAAA_AAAA_AAAA_AAAA},
            '{ROW_ITEM, FUNC_CONVERT, '0, 32'h8000_0000, 64'd0, 1'b0, 1'b0, '0}
        };

        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                wait_idle();
                cfg_write(directed_rows[i].idx, directed_rows[i].val[CFG_DATA_W-1:0]);
            end
            else
            begin
                drive_item(directed_rows[i].func, directed_rows[i].tick, directed_rows[i].val,
                           directed_rows[i].typed, directed_rows[i].exp_ok,
                           directed_rows[i].exp_time);
                pace();
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    ratio = '1;
                    guard = '1;
                end
                1:
                begin
                    ratio = '0;
                    guard = $urandom;
                end
                2:
                begin
                    ratio = 32'd1;
                    guard = '0;
                end
                default:
                begin
                    ratio = $urandom >> $urandom_range(24, 0);
                    if (ratio == '0)
                        ratio = 32'd1;
                    guard = ($urandom_range(3) == 0) ? '1 : $urandom >> $urandom_range(31, 0);
                end
            endcase
            wait_idle();
            cfg_write(CFG_RATIO_IDX, ratio);
            cfg_write(CFG_GUARD_IDX, guard);

            counted = 0;
            while (counted < ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(99);
                if (pick < 12)
                    func = FUNC_PUBLISH;
                else if (pick < 15)
                    func = FUNC_IGNORED;
                else if (pick < 57)
                    func = FUNC_CONVERT;
                else
                    func = FUNC_GUARDED;

                pick = $urandom_range(9);
                if (func == FUNC_PUBLISH || pick < 2)
                    tick = $urandom;
                else if (pick == 2)
                    tick = last_anchor_tick + ($urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
                else
                begin
                    delta = $urandom >> $urandom_range(31, 1);
                    tick = $urandom_range(1) ? last_anchor_tick + delta : last_anchor_tick - delta;
                end

                pick = $urandom_range(9);
                if (pick == 0)
                    sample = {32'hFFFF_FFFF, 32'($urandom)};
                else if (pick == 1)
                    sample = {32'd0, 32'($urandom)};
                else
                    sample = {32'($urandom), 32'($urandom)};

                drive_item(func, tick, sample, 1'b0, 1'b0, '0);
                if (func != FUNC_IGNORED)
                    counted++;
                pace();
            end
        end

        wait_idle();

        $display("Run covered %0d input transactions (%0d anchor updates, %0d ignored) and %0d results.",
                 n_accepted, n_publish, n_ignored, n_results);
        $display("Of the results %0d had ok clear and %0d saturated; %0d register writes were made.",
                 n_not_ok, n_saturated, n_cfg_writes);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/tts_pkg.sv
rtl/tts_req_if.sv
rtl/tts_rsp_if.sv
rtl/tts_cfg_if.sv
rtl/tts_cfg_regs.sv
rtl/tts_front.sv
rtl/tts_back.sv
rtl/timer_to_sample_timestamp.sv
dv/timer_to_sample_timestamp_tb.sv
